// ===== hw/rtl/acn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_pkg
// Shared types and constants for the axis calibrate/normalize block.
// ----------------------------------------------------------------------------
package acn_pkg;

	localparam int NUM_AXES    = 2;
	localparam int SAMPLE_BITS = 12;
	localparam int IN_BITS     = 12;
	localparam int PCT_W       = 7;
	localparam int REM_W       = SAMPLE_BITS + PCT_W;
	localparam int STEP_W      = $clog2(PCT_W);

	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PCT_W-1:0]       pct_t;

	typedef enum logic [1:0] {
		LANE_IDLE,
		LANE_LOAD,
		LANE_DIV,
		LANE_DONE
	} lane_state_t;

	// Per-lane result handed to the merge stage.
	typedef struct packed {
		logic done;
		logic zero;
		pct_t pct;
	} lane_res_t;

	// Control broadcast from the top level to every lane.
	typedef struct packed {
		logic start;
		logic calibrate;
		logic release_res;
	} lane_ctrl_t;

	function automatic sample_t min_reset(input int axis);
		sample_t v;
		case (axis)
			0:       v = SAMPLE_BITS'(820);
			1:       v = SAMPLE_BITS'(739);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic sample_t max_reset(input int axis);
		sample_t v;
		case (axis)
			0:       v = SAMPLE_BITS'(3101);
			1:       v = SAMPLE_BITS'(3100);
			default: v = '1;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/acn_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_in_if
// Sample channel: one X/Y sample pair and a calibrate flag per beat.
// ----------------------------------------------------------------------------
interface acn_in_if;
	logic                         valid;
	logic                         ready;
	logic [acn_pkg::IN_BITS-1:0]  x_sample;
	logic [acn_pkg::IN_BITS-1:0]  y_sample;
	logic                         calibrate;

	modport source (output valid, output x_sample, output y_sample, output calibrate,
		input ready);
	modport sink (input valid, input x_sample, input y_sample, input calibrate,
		output ready);
endinterface

// ===== hw/rtl/acn_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_out_if
// Result channel: X/Y percentages and the zero-range flag per beat.
// ----------------------------------------------------------------------------
interface acn_out_if;
	logic                        valid;
	logic                        ready;
	logic [acn_pkg::PCT_W-1:0]   x_percent;
	logic [acn_pkg::PCT_W-1:0]   y_percent;
	logic                        zero_range;

	modport source (output valid, output x_percent, output y_percent, output zero_range,
		input ready);
	modport sink (input valid, input x_percent, input y_percent, input zero_range,
		output ready);
endinterface

// ===== hw/rtl/acn_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_lane
// One axis: min/max tracking and a restoring divider that yields the
// clamped percentage one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acn_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  acn_pkg::lane_ctrl_t ctrl,
	input  acn_pkg::sample_t    sample,
	input  acn_pkg::sample_t    min_init,
	input  acn_pkg::sample_t    max_init,
	output acn_pkg::lane_res_t  res
);
	import acn_pkg::*;

	lane_state_t         state_q, state_d;
	sample_t             sample_q;
	sample_t             min_q;
	sample_t             max_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W-1:0]    dvs_q;
	pct_t                quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                zero_q;

	sample_t             range;
	sample_t             diff;
	logic                is_zero;
	logic                at_low;
	logic                at_high;
	logic                last_step;
	logic                fits;

	assign range     = max_q - min_q;
	assign diff      = sample_q - min_q;
	assign is_zero   = (range == '0);
	assign at_low    = (sample_q <= min_q);
	assign at_high   = (sample_q >= max_q);
	assign last_step = (step_q == STEP_W'(PCT_W - 1));
	assign fits      = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LANE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LANE_IDLE: begin
				if (ctrl.start) begin
					state_d = LANE_LOAD;
				end
			end
			LANE_LOAD: begin
				if (is_zero || at_low || at_high) begin
					state_d = LANE_DONE;
				end else begin
					state_d = LANE_DIV;
				end
			end
			LANE_DIV: begin
				if (last_step) begin
					state_d = LANE_DONE;
				end
			end
			LANE_DONE: begin
				if (ctrl.release_res) begin
					state_d = LANE_IDLE;
				end
			end
			default: state_d = LANE_IDLE;
		endcase
	end

	// The stored extremes reset to the calibration defaults of this axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= min_init;
			max_q <= max_init;
		end else if (state_q == LANE_IDLE && ctrl.start && ctrl.calibrate) begin
			if (sample < min_q) begin
				min_q <= sample;
			end
			if (sample > max_q) begin
				max_q <= sample;
			end
		end
	end

	// Between min and max the quotient is below 100, so seven quotient bits
	// are enough and the divisor starts shifted left by six.
	always_ff @(posedge clk) begin
		case (state_q)
			LANE_IDLE: begin
				if (ctrl.start) begin
					sample_q <= sample;
				end
			end
			LANE_LOAD: begin
				zero_q <= is_zero;
				step_q <= '0;
				rem_q  <= REM_W'(diff) * REM_W'(PCT_FULL);
				dvs_q  <= REM_W'(range) << (PCT_W - 1);
				if (is_zero || at_low) begin
					quo_q <= '0;
				end else if (at_high) begin
					quo_q <= PCT_FULL;
				end else begin
					quo_q <= '0;
				end
			end
			LANE_DIV: begin
				if (fits) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q  <= {quo_q[PCT_W-2:0], fits};
				dvs_q  <= dvs_q >> 1;
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign res.done = (state_q == LANE_DONE);
	assign res.zero = zero_q;
	assign res.pct  = quo_q;

endmodule

// ===== hw/rtl/acn_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_merge
// Gathers the lane results into one output register and drives the
// result channel.
// ----------------------------------------------------------------------------
module acn_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  acn_pkg::lane_res_t lanes [acn_pkg::NUM_AXES],
	output logic               load,
	acn_out_if.source          out_ch
);
	import acn_pkg::*;

	logic all_done;
	logic any_zero;
	pct_t x_pct;
	pct_t y_pct;
	logic valid_q;
	pct_t x_q;
	pct_t y_q;
	logic zero_q;

	always_comb begin
		all_done = 1'b1;
		any_zero = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			all_done = all_done & lanes[a].done;
			any_zero = any_zero | lanes[a].zero;
		end
	end

	assign x_pct = lanes[0].pct;
	assign y_pct = (NUM_AXES > 1) ? lanes[NUM_AXES > 1 ? 1 : 0].pct : '0;

	// The register refills in the same cycle the waiting beat is taken.
	assign load = all_done && (!valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= x_pct;
			y_q    <= y_pct;
			zero_q <= any_zero;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.x_percent  = x_q;
	assign out_ch.y_percent  = y_q;
	assign out_ch.zero_range = zero_q;

endmodule

// ===== hw/rtl/axis_calibrate_normalize_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_calibrate_normalize_core
// Two-axis min/max calibration with clamped percentage output.
//
// in_ch carries one X/Y sample pair per beat with a calibrate flag. With the
// flag set, each axis first widens its stored min/max to include the sample.
// out_ch returns one beat per input beat: each axis as
// (sample - min) * 100 / (max - min) clamped to 0..100, and zero_range set
// when an axis has max equal to min (that axis then reads 0).
// Each axis runs in its own lane; a merge stage joins the lanes into the
// output register.
// A sample that lies strictly between min and max passes the load step and the
// 7-step restoring divider in its lane before its result is registered for
// output; samples at or outside the extremes skip the divider.
// One item is in flight at a time.
// The input accepts the next beat while a finished result still waits in the
// output register; if the receiver stalls longer, the lanes hold their result
// and in_ch.ready stays low. Reset loads the default extremes
// (X 820..3101, Y 739..3100) and empties the output register.
// ----------------------------------------------------------------------------
module axis_calibrate_normalize_core (
	input  logic      clk,
	input  logic      arst_n,
	acn_in_if.sink    in_ch,
	acn_out_if.source out_ch
);
	import acn_pkg::*;

	logic       busy_q;
	logic       accept;
	logic       load;
	lane_ctrl_t ctrl;
	lane_res_t  lanes [NUM_AXES];
	sample_t    samples [NUM_AXES];

	assign in_ch.ready = !busy_q;
	assign accept      = in_ch.valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (load) begin
			busy_q <= 1'b0;
		end
	end

	assign ctrl.start       = accept;
	assign ctrl.calibrate   = in_ch.calibrate;
	assign ctrl.release_res = load;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		// Axes beyond Y have no input field and see a zero sample.
		if (a == 0) begin : g_x
			assign samples[a] = SAMPLE_BITS'(in_ch.x_sample);
		end else if (a == 1) begin : g_y
			assign samples[a] = SAMPLE_BITS'(in_ch.y_sample);
		end else begin : g_extra
			assign samples[a] = '0;
		end

		acn_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sample   (samples[a]),
			.min_init (min_reset(a)),
			.max_init (max_reset(a)),
			.res      (lanes[a])
		);
	end

	acn_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.lanes  (lanes),
		.load   (load),
		.out_ch (out_ch)
	);

endmodule

// ===== bench/axis_calibrate_normalize_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_calibrate_normalize_core_tb
// Self-checking bench for the two-axis calibrate/normalize core.
//
// Sample pairs go in on in_ch, some of them with the calibrate flag set. A
// scoreboard keeps its own copy of the stored extremes, widens them on
// calibrate beats, and works out the clamped percentages for every accepted
// beat. Each out_ch beat is compared field by field with the oldest entry.
// Both sides drop valid/ready at random, except for one stretch that runs at
// full rate.
// ----------------------------------------------------------------------------
module axis_calibrate_normalize_core_tb;
	import acn_pkg::*;

	localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
	localparam int X_MIN_RST   = 820;
	localparam int Y_MIN_RST   = 739;
	localparam int X_MAX_RST   = 3101;
	localparam int Y_MAX_RST   = 3100;
	localparam int SCALE       = 100;
	localparam int IDLE_PCT    = 37;
	localparam int RAND_ITEMS  = 1600;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		pct_t x_pct;
		pct_t y_pct;
		logic zero;
	} norm_result_t;

	class calib_scoreboard;
		sample_t      lo[2];
		sample_t      hi[2];
		norm_result_t pending_q[$];
		int           errors;

		function new();
			lo[0] = sample_t'(X_MIN_RST);
			lo[1] = sample_t'(Y_MIN_RST);
			hi[0] = sample_t'(X_MAX_RST);
			hi[1] = sample_t'(Y_MAX_RST);
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Truncating signed division, clamped to 0..100. A flat range reads 0.
		function pct_t percent_of(sample_t s, sample_t l, sample_t h, ref logic zero);
			longint span;
			longint q;
			span = longint'(h) - longint'(l);
			if (span == 0) begin
				zero = 1'b1;
				return '0;
			end
			q = ((longint'(s) - longint'(l)) * SCALE) / span;
			if (q > SCALE)
				return pct_t'(SCALE);
			if (q < 0)
				return '0;
			return pct_t'(q);
		endfunction

		function void note_sample(sample_t xs, sample_t ys, logic cal);
			sample_t      s[2];
			norm_result_t r;
			s[0] = xs;
			s[1] = ys;
			r.zero = 1'b0;
			if (cal) begin
				for (int a = 0; a < 2; a++) begin
					if (s[a] < lo[a])
						lo[a] = s[a];
					if (s[a] > hi[a])
						hi[a] = s[a];
				end
			end
			r.x_pct = percent_of(s[0], lo[0], hi[0], r.zero);
			r.y_pct = percent_of(s[1], lo[1], hi[1], r.zero);
			pending_q.push_back(r);
		endfunction

		task check_result(pct_t xp, pct_t yp, logic zr);
			norm_result_t e;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected beat x=%0d y=%0d zero=%0b", xp, yp, zr));
				return;
			end
			e = pending_q.pop_front();
			if (xp !== e.x_pct)
				report($sformatf("x_percent %0d, want %0d", xp, e.x_pct));
			if (yp !== e.y_pct)
				report($sformatf("y_percent %0d, want %0d", yp, e.y_pct));
			if (zr !== e.zero)
				report($sformatf("zero_range %0b, want %0b", zr, e.zero));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic burst;
	int   cycles;

	calib_scoreboard sb;

	acn_in_if  in_ch ();
	acn_out_if out_ch ();

	axis_calibrate_normalize_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= burst || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			sb.note_sample(in_ch.x_sample, in_ch.y_sample, in_ch.calibrate);
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.x_percent, out_ch.y_percent, out_ch.zero_range);
	end

	task automatic send_sample(int xs, int ys, logic cal);
		while (!burst && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.x_sample  <= sample_t'(xs);
		in_ch.y_sample  <= sample_t'(ys);
		in_ch.calibrate <= cal;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Most samples sit close to the stored extremes, where the clamp and the
	// small quotients live. Calibrate beats widen the extremes only a little,
	// so the range stays narrow enough to matter for most of the run.
	function automatic int pick_sample(int axis, logic cal);
		int v;
		if (cal) begin
			if ($urandom_range(1) == 0)
				v = int'(sb.lo[axis]) - int'($urandom_range(24));
			else
				v = int'(sb.hi[axis]) + int'($urandom_range(24));
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3: v = int'($urandom_range(SAMPLE_TOP));
				4, 5, 6:    v = int'(sb.lo[axis]) + int'($urandom_range(16)) - 8;
				default:    v = int'(sb.hi[axis]) + int'($urandom_range(16)) - 8;
			endcase
		end
		if (v < 0)
			v = 0;
		if (v > SAMPLE_TOP)
			v = SAMPLE_TOP;
		return v;
	endfunction

	initial begin
		logic cal;
		sb = new();
		arst_n          = 1'b0;
		burst           = 1'b0;
		cycles          = 0;
		in_ch.valid     = 1'b0;
		in_ch.x_sample  = '0;
		in_ch.y_sample  = '0;
		in_ch.calibrate = 1'b0;
		out_ch.ready    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset extremes: below, at, just inside and above each bound.
		send_sample(0, 0, 1'b0);
		send_sample(SAMPLE_TOP, SAMPLE_TOP, 1'b0);
		send_sample(X_MIN_RST, Y_MIN_RST, 1'b0);
		send_sample(X_MAX_RST, Y_MAX_RST, 1'b0);
		send_sample(X_MIN_RST + 1, Y_MIN_RST + 1, 1'b0);
		send_sample(X_MAX_RST - 1, Y_MAX_RST - 1, 1'b0);
		send_sample(X_MIN_RST - 1, Y_MIN_RST - 1, 1'b0);
		send_sample(X_MAX_RST + 1, Y_MAX_RST + 1, 1'b0);
		send_sample(1960, 1919, 1'b0);
		send_sample('hAAA, 'h555, 1'b0);
		send_sample('h555, 'hAAA, 1'b0);
		// Calibration inside the range, then widening on each side.
		send_sample(2000, 2000, 1'b1);
		send_sample(800, 3200, 1'b1);
		send_sample(3150, 700, 1'b1);
		send_sample(800, 700, 1'b0);
		send_sample(3150, 3200, 1'b0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			burst = (i >= 500 && i < 800);
			cal   = ($urandom_range(11) == 0);
			send_sample(pick_sample(0, cal), pick_sample(1, cal), cal);
		end
		burst = 1'b0;

		// Open both axes to full scale at the end.
		send_sample(0, SAMPLE_TOP, 1'b1);
		send_sample(SAMPLE_TOP, 0, 1'b1);
		send_sample(0, 0, 1'b0);
		send_sample(SAMPLE_TOP, SAMPLE_TOP, 1'b0);
		send_sample(2048, 2047, 1'b0);
		send_sample(1, SAMPLE_TOP - 1, 1'b1);
		in_ch.valid <= 1'b0;

		// One more edge lets the monitor log the last accepted beat.
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
